>>> rtl/mrf_pkg.sv
package mrf_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LIMIT  = 1'd1;

  localparam logic [7:0] NODE_ADDRESS_RST = 8'd1;
  localparam logic [7:0] FRAME_LIMIT_RST  = 8'd255;

  // Result status codes
  localparam logic [2:0] ST_PENDING  = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_GOOD     = 3'd2;
  localparam logic [2:0] ST_OTHER    = 3'd3;
  localparam logic [2:0] ST_CRC_ERR  = 3'd4;
  localparam logic [2:0] ST_RESTART  = 3'd5;

  // Exception codes
  localparam logic [1:0] EXC_NONE      = 2'd0;
  localparam logic [1:0] EXC_BAD_FUNC  = 2'd1;
  localparam logic [1:0] EXC_BAD_ADDR  = 2'd2;
  localparam logic [1:0] EXC_BAD_COUNT = 2'd3;

  // Function codes
  localparam logic [7:0] FN_READ_COILS     = 8'd1;
  localparam logic [7:0] FN_READ_DISCRETE  = 8'd2;
  localparam logic [7:0] FN_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FN_READ_INPUT     = 8'd4;
  localparam logic [7:0] FN_WRITE_COILS    = 8'd15;
  localparam logic [7:0] FN_WRITE_REGS     = 8'd16;

  // Count limits
  localparam logic [15:0] MAX_COILS = 16'd2000;
  localparam logic [15:0] MAX_REGS  = 16'd125;

  // Frame geometry
  localparam logic [7:0] HDR_BYTES = 8'd7;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] item_count;
    logic [1:0]  exception_code;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [2:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] item_count;
    logic [7:0]  byte_count;
  } job_t;

endpackage

>>> rtl/mrf_front.sv
module mrf_front
  import mrf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   job_valid,
  input  logic                   job_ready,
  output job_t                   job
);

  logic [7:0]  node_r, node_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  hdr_r [7];
  logic [7:0]  hdr_nxt [7];
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] lag_r, lag_nxt;
  logic [7:0]  recent_r, recent_nxt;

  logic        acc;
  logic        is_write;
  logic [8:0]  pos9;
  logic [8:0]  bytes9;
  logic [8:0]  len9;

  // Bitwise Modbus CRC-16 byte step, reflected poly A001
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (x[0]) x = (x >> 1) ^ 16'hA001;
      else      x = x >> 1;
    end
    return x;
  endfunction

  assign in_ready  = job_ready;
  assign acc       = in_valid && in_ready;
  assign job_valid = in_valid;

  assign is_write = (hdr_r[1] == FN_WRITE_COILS) || (hdr_r[1] == FN_WRITE_REGS);
  assign pos9     = {1'b0, pos_r};
  assign bytes9   = {1'b0, hdr_r[6]};
  assign len9     = is_write ? (9'd9 + bytes9) : 9'd8;

  // Config writes
  always_comb begin
    node_nxt  = node_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ADDRESS: node_nxt  = cfg_wdata;
        CFG_FRAME_LIMIT:  limit_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame tracking and classification
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    lag_nxt    = lag_r;
    recent_nxt = recent_r;
    for (int i = 0; i < 7; i++) hdr_nxt[i] = hdr_r[i];
    job        = '0;
    job.status = ST_PENDING;

    if (in_item.action) begin
      job.status = ST_RESTART;
    end else if (pos_r >= limit_r) begin
      job.status = ST_OVERFLOW;
    end else begin
      for (int i = 0; i < 7; i++) begin
        if (pos_r == 8'(i)) hdr_nxt[i] = in_item.rx_byte;
      end
      lag_nxt    = crc_r;
      crc_nxt    = crc_byte(crc_r, in_item.rx_byte);
      recent_nxt = in_item.rx_byte;
      pos_nxt    = pos_r + 8'd1;

      // header is complete from position 7 on
      if (pos_r >= HDR_BYTES) begin
        if (is_write && (pos9 < (9'd7 + bytes9))) begin
          job.payload_valid = 1'b1;
          job.payload_index = pos_r - HDR_BYTES;
          job.payload_byte  = in_item.rx_byte;
        end
        if ((pos9 + 9'd1) == len9) begin
          job.function_code = hdr_r[1];
          job.start_address = {hdr_r[2], hdr_r[3]};
          job.item_count    = {hdr_r[4], hdr_r[5]};
          job.byte_count    = hdr_r[6];
          // frame CRC is low byte first; compare against CRC before those two bytes
          if ({in_item.rx_byte, recent_r} != lag_r) job.status = ST_CRC_ERR;
          else if (hdr_r[0] != node_r)              job.status = ST_OTHER;
          else                                      job.status = ST_GOOD;
        end
      end
    end

    // restart and end of frame both return to the idle frame state
    if (job.status == ST_RESTART || job.status == ST_CRC_ERR ||
        job.status == ST_OTHER || job.status == ST_GOOD) begin
      pos_nxt    = '0;
      crc_nxt    = 16'hFFFF;
      lag_nxt    = 16'hFFFF;
      recent_nxt = '0;
      for (int i = 0; i < 7; i++) hdr_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r   <= NODE_ADDRESS_RST;
      limit_r  <= FRAME_LIMIT_RST;
      pos_r    <= '0;
      crc_r    <= 16'hFFFF;
      lag_r    <= 16'hFFFF;
      recent_r <= '0;
      for (int i = 0; i < 7; i++) hdr_r[i] <= '0;
    end else begin
      node_r  <= node_nxt;
      limit_r <= limit_nxt;
      if (acc) begin
        pos_r    <= pos_nxt;
        crc_r    <= crc_nxt;
        lag_r    <= lag_nxt;
        recent_r <= recent_nxt;
        for (int i = 0; i < 7; i++) hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_item.action |=> pos_r == 8'd0 && crc_r == 16'hFFFF)
    else $error("restart did not clear frame state");

  a_overflow_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_item.action && (pos_r >= limit_r) |=> $stable(pos_r) && $stable(crc_r))
    else $error("dropped byte changed frame state");

endmodule

>>> rtl/mrf_queue.sv
module mrf_queue
  import mrf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST) ? '0 : wr_r + PTR_W'(1);
    if (pop)  rd_nxt = (rd_r == LAST) ? '0 : rd_r + PTR_W'(1);
    if (push && !pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("queue count above depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count did not grow on push");

endmodule

>>> rtl/mrf_back.sv
module mrf_back
  import mrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic [1:0]  exc;
  logic [15:0] maxc;
  logic        range_bad;
  logic        addr_bad;
  logic [16:0] coil_bytes;
  logic [16:0] reg_bytes;

  assign job_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Request checks for a good frame
  always_comb begin
    maxc = ((job.function_code == FN_READ_COILS) || (job.function_code == FN_READ_DISCRETE) ||
            (job.function_code == FN_WRITE_COILS)) ? MAX_COILS : MAX_REGS;
    range_bad  = (job.item_count == 16'd0) || (job.item_count > maxc);
    addr_bad   = ({1'b0, job.start_address} + {1'b0, job.item_count}) > 17'h0FFFF;
    coil_bytes = ({1'b0, job.item_count} + 17'd7) >> 3;
    reg_bytes  = {job.item_count, 1'b0};

    unique case (job.function_code) inside
      FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING, FN_READ_INPUT: begin
        exc = range_bad ? EXC_BAD_COUNT : (addr_bad ? EXC_BAD_ADDR : EXC_NONE);
      end
      FN_WRITE_COILS: begin
        exc = range_bad ? EXC_BAD_COUNT : (addr_bad ? EXC_BAD_ADDR :
              ((17'(job.byte_count) != coil_bytes) ? EXC_BAD_COUNT : EXC_NONE));
      end
      FN_WRITE_REGS: begin
        exc = range_bad ? EXC_BAD_COUNT : (addr_bad ? EXC_BAD_ADDR :
              ((17'(job.byte_count) != reg_bytes) ? EXC_BAD_COUNT : EXC_NONE));
      end
      default: exc = EXC_BAD_FUNC;
    endcase
    if (job.status != ST_GOOD) exc = EXC_NONE;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (job_ready) begin
      out_valid_nxt = job_valid;
      if (job_valid) begin
        out_item_nxt.status         = job.status;
        out_item_nxt.payload_valid  = job.payload_valid;
        out_item_nxt.payload_index  = job.payload_index;
        out_item_nxt.payload_byte   = job.payload_byte;
        out_item_nxt.function_code  = job.function_code;
        out_item_nxt.start_address  = job.start_address;
        out_item_nxt.item_count     = job.item_count;
        out_item_nxt.exception_code = exc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  a_exc_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.exception_code == EXC_NONE) ||
                    (out_item_r.status == ST_GOOD))
    else $error("exception code on a frame not handled");

endmodule

>>> rtl/modbus_rtu_request_framer_top.sv
// Channel   Ports                               Moves
// --------  ----------------------------------  -------------------------------
// input     in_valid / in_ready / in_item       one received byte or restart
// result    out_valid / out_ready / out_item    one result per input item
// config    cfg_we / cfg_index / cfg_wdata      node address, frame limit
//
// One item per cycle sustained when nothing stalls; an accepted item is written into the queue
// at the accept edge, then passes to the output register, where its result is shown.
// The byte-to-byte CRC and frame position update in the front sets the rate.
// Reset (synchronous, rst_n low) empties the queue and output and restores
// frame state and registers. A stalled output fills the queue, then in_ready drops.
module modbus_rtu_request_framer_top
  import mrf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  logic job_valid_f, job_ready_f;
  job_t job_f;
  logic job_valid_b, job_ready_b;
  job_t job_b;

  mrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_valid_f),
    .job_ready (job_ready_f),
    .job       (job_f)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid_f),
    .push_ready (job_ready_f),
    .push_data  (job_f),
    .pop_valid  (job_valid_b),
    .pop_ready  (job_ready_b),
    .pop_data   (job_b)
  );

  mrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid_b),
    .job_ready (job_ready_b),
    .job       (job_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
